// ===== src/sha1_message_digest_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, quiet while in reset.
`define SMD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while in reset.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sha1md_pkg.sv =====
package sha1md_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        is_final_word;
	} digest_item_t;

	// One 32-bit message word on its way from the front to the round engine
	typedef struct packed {
		logic [31:0] word;
		logic        msg_end;
	} q_entry_t;

	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS      = 80;

	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [7:0] PAD_MARKER    = 8'h80;

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] w;
		unique case (idx)
			3'd0:    w = 32'h67452301;
			3'd1:    w = 32'hEFCDAB89;
			3'd2:    w = 32'h98BADCFE;
			3'd3:    w = 32'h10325476;
			default: w = 32'hC3D2E1F0;
		endcase
		return w;
	endfunction

endpackage

// ===== src/sha1md_front.sv =====
module sha1md_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  sha1md_pkg::byte_item_t byte_item,
	output logic                  push,
	output sha1md_pkg::q_entry_t  push_entry,
	input  logic                  q_full
);
	import sha1md_pkg::*;

	typedef enum logic [1:0] {ST_BYTES, ST_MARK, ST_FILL} state_t;

	state_t      state_q;
	logic [60:0] count_q;
	logic [60:0] cnt_next;
	logic [23:0] acc_q;
	logic [3:0]  pw_q;
	logic        len_ok_q;
	logic        take;
	logic [31:0] marker_word;

	assign byte_stall = (state_q != ST_BYTES) || q_full;
	assign take       = byte_valid && !byte_stall;
	assign cnt_next   = count_q + 61'd1;

	// first padding word: pending bytes, then the marker, then zeros
	always_comb begin
		case (count_q[1:0])
			2'd0:    marker_word = {PAD_MARKER, 24'h0};
			2'd1:    marker_word = {acc_q[7:0], PAD_MARKER, 16'h0};
			2'd2:    marker_word = {acc_q[15:0], PAD_MARKER, 8'h0};
			default: marker_word = {acc_q[23:0], PAD_MARKER};
		endcase
	end

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		unique case (state_q)
			ST_BYTES: begin
				push            = take && (count_q[1:0] == 2'd3);
				push_entry.word = {acc_q, byte_item.data_byte};
			end
			ST_MARK: begin
				push            = !q_full;
				push_entry.word = marker_word;
			end
			ST_FILL: begin
				push = !q_full;
				// length in bits sits in words 14 and 15 of the final block
				if (len_ok_q && pw_q == 4'd14) begin
					push_entry.word = count_q[60:29];
				end else if (len_ok_q && pw_q == 4'd15) begin
					push_entry.word    = {count_q[28:0], 3'b000};
					push_entry.msg_end = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_BYTES;
			count_q  <= '0;
			pw_q     <= '0;
			len_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_BYTES: begin
					if (take) begin
						count_q <= cnt_next;
						if (byte_item.is_last) begin
							state_q <= ST_MARK;
							pw_q    <= cnt_next[5:2];
						end
					end
				end
				ST_MARK: begin
					if (!q_full) begin
						pw_q     <= pw_q + 4'd1;
						// no room for the length here: it goes into a fresh block
						len_ok_q <= (pw_q < 4'd14) || (pw_q == 4'd15);
						state_q  <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!q_full) begin
						pw_q <= pw_q + 4'd1;
						if (len_ok_q && pw_q == 4'd15) begin
							state_q  <= ST_BYTES;
							count_q  <= '0;
							len_ok_q <= 1'b0;
						end else if (pw_q == 4'd15) begin
							len_ok_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_BYTES;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= {acc_q[15:0], byte_item.data_byte};
		end
	end

endmodule

// ===== src/sha1md_queue.sv =====
module sha1md_queue #(
	parameter int Depth = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sha1md_pkg::q_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output sha1md_pkg::q_entry_t pop_entry,
	output logic                 empty
);
	import sha1md_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	q_entry_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(Depth));
	assign empty     = (cnt_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== src/sha1md_back.sv =====
module sha1md_back (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     pop,
	input  sha1md_pkg::q_entry_t     pop_entry,
	input  logic                     empty,
	output logic                     digest_valid,
	input  logic                     digest_stall,
	output sha1md_pkg::digest_item_t digest_item
);
	import sha1md_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_ADD, ST_OUT} state_t;

	state_t      state_q;
	logic [3:0]  ld_cnt_q;
	logic [6:0]  round_q;
	logic        end_q;
	logic [2:0]  out_idx_q;
	logic        digest_valid_q;
	logic [31:0] h_q [5];
	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_next;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic        last_load;

	assign pop       = (state_q == ST_LOAD) && !empty;
	assign last_load = pop && (ld_cnt_q == 4'(BLOCK_WORDS - 1));

	// schedule word sixteen rounds ahead of the one in win_q[0]
	assign w_next = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
		win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + win_q[0];

	assign digest_valid              = digest_valid_q;
	assign digest_item.digest_word   = h_q[out_idx_q];
	assign digest_item.word_index    = out_idx_q;
	assign digest_item.is_final_word = (out_idx_q == LAST_WORD_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			ld_cnt_q       <= '0;
			round_q        <= '0;
			end_q          <= 1'b0;
			out_idx_q      <= '0;
			digest_valid_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= iv_word(3'(i));
			end
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						ld_cnt_q <= ld_cnt_q + 4'd1;
						end_q    <= pop_entry.msg_end;
						if (last_load) begin
							state_q <= ST_RUN;
							round_q <= '0;
						end
					end
				end
				ST_RUN: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'(ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					round_q <= '0;
					if (end_q) begin
						state_q        <= ST_OUT;
						out_idx_q      <= '0;
						digest_valid_q <= 1'b1;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						if (out_idx_q == LAST_WORD_IDX) begin
							digest_valid_q <= 1'b0;
							state_q        <= ST_LOAD;
							for (int i = 0; i < 5; i++) begin
								h_q[i] <= iv_word(3'(i));
							end
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop || state_q == ST_RUN) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= (state_q == ST_RUN) ? w_next : pop_entry.word;
		end
		if (last_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == ST_RUN) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

// ===== src/sha1_message_digest.sv =====
// SHA-1 over a byte stream. One message byte per beat on the byte channel, the final byte
// flagged with is_last; five digest beats follow on the digest channel, word 0 (most
// significant) first, word 4 flagged is_final_word. Empty messages cannot be sent. The front
// takes a byte each cycle while the word queue has room and adds the padding itself (up to 18
// words, one a cycle while the queue has room, during which bytes are stalled). The round
// engine loads a block of 16 words from the queue, runs 80 rounds and adds the result into
// the chain for each 64-byte block; its throughput is set by the single round unit. The queue
// lets the next block arrive while rounds run. While the digest leaves, the next message's
// bytes may already flow in.
module sha1_message_digest #(
	parameter int QueueDepth = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  sha1md_pkg::byte_item_t   byte_item,
	output logic                     digest_valid,
	input  logic                     digest_stall,
	output sha1md_pkg::digest_item_t digest_item
);
	import sha1md_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     q_full;
	logic     pop;
	q_entry_t pop_entry;
	logic     q_empty;

	sha1md_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	sha1md_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	sha1md_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_entry    (pop_entry),
		.empty        (q_empty),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_item  (digest_item)
	);

endmodule

// ===== src/sha1md_checker.sv =====
`include "sha1_message_digest_defines.svh"

module sha1md_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     byte_valid,
	input logic                     byte_stall,
	input sha1md_pkg::byte_item_t   byte_item,
	input logic                     digest_valid,
	input logic                     digest_stall,
	input sha1md_pkg::digest_item_t digest_item
);
	import sha1md_pkg::*;

	logic byte_beat;
	logic digest_beat;

	assign byte_beat   = byte_valid && !byte_stall;
	assign digest_beat = digest_valid && !digest_stall;

	`SMD_ASSERT_NEXT(a_digest_hold, digest_valid && digest_stall, digest_valid && $stable(digest_item), "digest beat changed while stalled")

	`SMD_ASSERT_SAME(a_final_flag, digest_valid, digest_item.is_final_word == (digest_item.word_index == LAST_WORD_IDX), "final flag does not match word index")

	`SMD_ASSERT_NEXT(a_word_order, digest_beat && !digest_item.is_final_word, digest_valid && (digest_item.word_index == $past(digest_item.word_index) + 3'd1), "digest words out of order")

	`SMD_ASSERT_NEXT(a_digest_done, digest_beat && digest_item.is_final_word, !digest_valid, "digest beat after the final word")

	`SMD_ASSERT_NEXT(a_pad_stall, byte_beat && byte_item.is_last, byte_stall, "byte taken while padding")

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);
